// ===== rtl/core/erle_pkg.sv =====
package erle_pkg;

	localparam int ADDR_BITS_DEF  = 16;
	localparam int PAGE_COUNT_DEF = 12;

	localparam logic [7:0] ESC_BYTE = 8'hED;

	localparam logic [7:0]  PAGE_HI   = 8'd4;
	localparam logic [7:0]  PAGE_TOP  = 8'd5;
	localparam logic [7:0]  PAGE_LO   = 8'd8;
	localparam logic [15:0] BASE_HI   = 16'h8000;
	localparam logic [15:0] BASE_TOP  = 16'hC000;
	localparam logic [15:0] BASE_LO   = 16'h4000;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  value;
		logic [7:0]  count;
		logic        last;
	} erle_res_t;

	// Up to two results come out of one item; cnt says how many are meaningful.
	typedef struct packed {
		logic [1:0] cnt;
		erle_res_t  r0;
		erle_res_t  r1;
	} erle_pair_t;

endpackage

// ===== rtl/core/erle_dec.sv =====
module erle_dec #(
	parameter int ADDR_BITS  = erle_pkg::ADDR_BITS_DEF,
	parameter int PAGE_COUNT = erle_pkg::PAGE_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                action,
	input  logic [7:0]          page,
	input  logic [7:0]          data_byte,
	output erle_pkg::erle_pair_t res
);
	import erle_pkg::*;

	typedef enum logic [1:0] {PH_LIT, PH_ESC1, PH_ESC2, PH_VAL} phase_t;

	phase_t                 phase_q, phase_d;
	logic [7:0]             held_q, held_d;
	logic [ADDR_BITS-1:0]   addr_q, addr_d;
	logic [ADDR_BITS-1:0]   addr_p1;
	logic [ADDR_BITS-1:0]   base;
	logic                   is_esc;

	assign addr_p1 = addr_q + ADDR_BITS'(1);
	assign is_esc  = (data_byte == ESC_BYTE);

	always_comb begin
		base = '0;
		if ({1'b0, page} < 9'(PAGE_COUNT)) begin
			unique case (page)
				PAGE_HI:  base = ADDR_BITS'(BASE_HI);
				PAGE_TOP: base = ADDR_BITS'(BASE_TOP);
				PAGE_LO:  base = ADDR_BITS'(BASE_LO);
				default:  base = '0;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		addr_d  = addr_q;
		res.cnt = 2'd0;
		res.r0  = '{addr: addr_q[15:0], value: data_byte, count: 8'd1, last: 1'b1};
		res.r1  = '{addr: addr_p1[15:0], value: data_byte, count: 8'd1, last: 1'b1};
		if (!action) begin
			addr_d  = base;
			phase_d = PH_LIT;
			held_d  = 8'd0;
		end else begin
			unique case (phase_q)
				PH_LIT: begin
					if (is_esc) begin
						phase_d = PH_ESC1;
					end else begin
						res.cnt = 2'd1;
						addr_d  = addr_p1;
					end
				end
				PH_ESC1: begin
					if (is_esc) begin
						phase_d = PH_ESC2;
					end else begin
						// A lone escape byte is a literal, followed by this byte.
						res.cnt      = 2'd2;
						res.r0.value = ESC_BYTE;
						res.r0.last  = 1'b0;
						addr_d       = addr_q + ADDR_BITS'(2);
						phase_d      = PH_LIT;
					end
				end
				PH_ESC2: begin
					held_d  = data_byte;
					phase_d = PH_VAL;
				end
				PH_VAL: begin
					phase_d = PH_LIT;
					if (held_q != 8'd0) begin
						res.cnt      = 2'd1;
						res.r0.count = held_q;
						addr_d       = addr_q + ADDR_BITS'(held_q);
						held_d       = 8'd0;
					end
				end
				default: phase_d = PH_LIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LIT;
			held_q  <= 8'd0;
			addr_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			addr_q  <= addr_d;
		end
	end

	// A held run count only lives while its value byte is awaited.
	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != 8'd0) |-> (phase_q == PH_VAL))
		else $error("run count held outside value phase");

endmodule

// ===== rtl/core/escape_rle_memory_block_decoder_unit.sv =====
// Channel | Handshake            | Fields
// in      | in_valid / in_stall  | action, page, data_byte
// out     | out_valid / out_stall| write_addr, write_value, write_count, last
//
// One item passes an input register, the decode logic and the result register before its
// first result appears on the output.
// An item is taken every cycle while each gives at most one result and the output is not
// stalled; an item that gives two results holds the input while the second result waits
// in a spare register.
// A stalled output holds its result; the input register keeps taking one more item.
// Reset clears the decode phase, run count and address to zero and empties all stages.
module escape_rle_memory_block_decoder_unit #(
	parameter int ADDR_BITS  = erle_pkg::ADDR_BITS_DEF,
	parameter int PAGE_COUNT = erle_pkg::PAGE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  page,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] write_addr,
	output logic [7:0]  write_value,
	output logic [7:0]  write_count,
	output logic        last
);
	import erle_pkg::*;

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] page_s1;
	logic [7:0] byte_s1;

	erle_pair_t pair;
	erle_res_t  out_q;
	erle_res_t  pend_q;
	logic       out_valid_q;
	logic       pend_valid_q;
	logic       pop;
	logic       room;
	logic       go;

	assign pop      = out_valid_q && !out_stall;
	assign room     = !pend_valid_q && (!out_valid_q || pop);
	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			page_s1   <= page;
			byte_s1   <= data_byte;
		end
	end

	erle_dec #(
		.ADDR_BITS  (ADDR_BITS),
		.PAGE_COUNT (PAGE_COUNT)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.action    (action_s1),
		.page      (page_s1),
		.data_byte (byte_s1),
		.res       (pair)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (pend_valid_q) begin
			if (pop) begin
				pend_valid_q <= 1'b0;
			end
		end else if (go && pair.cnt != 2'd0) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= (pair.cnt == 2'd2);
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (pop) begin
				out_q <= pend_q;
			end
		end else if (go && pair.cnt != 2'd0) begin
			out_q  <= pair.r0;
			pend_q <= pair.r1;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_addr  = out_q.addr;
	assign write_value = out_q.value;
	assign write_count = out_q.count;
	assign last        = out_q.last;

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second result waiting without a first");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (!out_q.last && pend_q.last))
		else $error("last flag wrong on a result pair");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && pop) |=> (out_valid_q && !pend_valid_q && last))
		else $error("second result of a pair not moved up");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.count == 8'd0) |-> 1'b0)
		else $error("result with zero count");

endmodule
